// ===== hw/rtl/sgtr_pkg.sv =====
package sgtr_pkg;

  localparam int unsigned GlyphCols    = 5;
  localparam int unsigned GlyphRows    = 8;
  localparam int unsigned AdvanceCells = 6;

  localparam logic [1:0] RegInk   = 2'd0;
  localparam logic [1:0] RegPaper = 2'd1;
  localparam logic [1:0] RegScale = 2'd2;
  localparam logic [1:0] RegWrap  = 2'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       restart;
    logic [7:0] start_x;
    logic [7:0] start_y;
  } char_req_t;

  typedef struct packed {
    logic [7:0]  pix_x;
    logic [7:0]  pix_y;
    logic [15:0] fill_color;
    logic [3:0]  side;
    logic        last;
  } fill_req_t;

  // font column bytes, bit 0 is the top row
  function automatic logic [39:0] glyph_bits(input logic [7:0] code);
    logic [39:0] g;
    case (code)
      8'd0: g = 40'h0000000000; 8'd1: g = 40'h3E5B4F5B3E; 8'd2: g = 40'h3E6B4F6B3E;
      8'd3: g = 40'h1C3E7C3E1C; 8'd4: g = 40'h183C7E3C18; 8'd5: g = 40'h1C577D571C;
      8'd6: g = 40'h1C5E7F5E1C; 8'd7: g = 40'h00183C1800; 8'd8: g = 40'hFFE7C3E7FF;
      8'd9: g = 40'h0018241800; 8'd10: g = 40'hFFE7DBE7FF; 8'd11: g = 40'h30483A060E;
      8'd12: g = 40'h2629792926; 8'd13: g = 40'h407F050507; 8'd14: g = 40'h407F05253F;
      8'd15: g = 40'h5A3CE73C5A; 8'd16: g = 40'h7F3E1C1C08; 8'd17: g = 40'h081C1C3E7F;
      8'd18: g = 40'h14227F2214; 8'd19: g = 40'h5F5F005F5F; 8'd20: g = 40'h06097F017F;
      8'd21: g = 40'h006689956A; 8'd22: g = 40'h6060606060; 8'd23: g = 40'h94A2FFA294;
      8'd24: g = 40'h08047E0408; 8'd25: g = 40'h10207E2010; 8'd26: g = 40'h08082A1C08;
      8'd27: g = 40'h081C2A0808; 8'd28: g = 40'h1E10101010; 8'd29: g = 40'h0C1E0C1E0C;
      8'd30: g = 40'h30383E3830; 8'd31: g = 40'h060E3E0E06; 8'd32: g = 40'h0000000000;
      8'd33: g = 40'h00005F0000; 8'd34: g = 40'h0007000700; 8'd35: g = 40'h147F147F14;
      8'd36: g = 40'h242A7F2A12; 8'd37: g = 40'h2313086462; 8'd38: g = 40'h3649562050;
      8'd39: g = 40'h0008070300; 8'd40: g = 40'h001C224100; 8'd41: g = 40'h0041221C00;
      8'd42: g = 40'h2A1C7F1C2A; 8'd43: g = 40'h08083E0808; 8'd44: g = 40'h0080703000;
      8'd45: g = 40'h0808080808; 8'd46: g = 40'h0000606000; 8'd47: g = 40'h2010080402;
      8'd48: g = 40'h3E5149453E; 8'd49: g = 40'h00427F4000; 8'd50: g = 40'h7249494946;
      8'd51: g = 40'h2141494D33; 8'd52: g = 40'h1814127F10; 8'd53: g = 40'h2745454539;
      8'd54: g = 40'h3C4A494931; 8'd55: g = 40'h4121110907; 8'd56: g = 40'h3649494936;
      8'd57: g = 40'h464949291E; 8'd58: g = 40'h0000140000; 8'd59: g = 40'h0040340000;
      8'd60: g = 40'h0008142241; 8'd61: g = 40'h1414141414; 8'd62: g = 40'h0041221408;
      8'd63: g = 40'h0201590906; 8'd64: g = 40'h3E415D594E; 8'd65: g = 40'h7C1211127C;
      8'd66: g = 40'h7F49494936; 8'd67: g = 40'h3E41414122; 8'd68: g = 40'h7F4141413E;
      8'd69: g = 40'h7F49494941; 8'd70: g = 40'h7F09090901; 8'd71: g = 40'h3E41415173;
      8'd72: g = 40'h7F0808087F; 8'd73: g = 40'h00417F4100; 8'd74: g = 40'h2040413F01;
      8'd75: g = 40'h7F08142241; 8'd76: g = 40'h7F40404040; 8'd77: g = 40'h7F021C027F;
      8'd78: g = 40'h7F0408107F; 8'd79: g = 40'h3E4141413E; 8'd80: g = 40'h7F09090906;
      8'd81: g = 40'h3E4151215E; 8'd82: g = 40'h7F09192946; 8'd83: g = 40'h2649494932;
      8'd84: g = 40'h03017F0103; 8'd85: g = 40'h3F4040403F; 8'd86: g = 40'h1F2040201F;
      8'd87: g = 40'h3F4038403F; 8'd88: g = 40'h6314081463; 8'd89: g = 40'h0304780403;
      8'd90: g = 40'h6159494D43; 8'd91: g = 40'h007F414141; 8'd92: g = 40'h0204081020;
      8'd93: g = 40'h004141417F; 8'd94: g = 40'h0402010204; 8'd95: g = 40'h4040404040;
      8'd96: g = 40'h0003070800; 8'd97: g = 40'h2054547840; 8'd98: g = 40'h7F28444438;
      8'd99: g = 40'h3844444428; 8'd100: g = 40'h384444287F; 8'd101: g = 40'h3854545418;
      8'd102: g = 40'h00087E0902; 8'd103: g = 40'h18A4A49C78; 8'd104: g = 40'h7F08040478;
      8'd105: g = 40'h00447D4000; 8'd106: g = 40'h2040403D00; 8'd107: g = 40'h7F10284400;
      8'd108: g = 40'h00417F4000; 8'd109: g = 40'h7C04780478; 8'd110: g = 40'h7C08040478;
      8'd111: g = 40'h3844444438; 8'd112: g = 40'hFC18242418; 8'd113: g = 40'h18242418FC;
      8'd114: g = 40'h7C08040408; 8'd115: g = 40'h4854545424; 8'd116: g = 40'h04043F4424;
      8'd117: g = 40'h3C4040207C; 8'd118: g = 40'h1C2040201C; 8'd119: g = 40'h3C4030403C;
      8'd120: g = 40'h4428102844; 8'd121: g = 40'h4C9090907C; 8'd122: g = 40'h4464544C44;
      8'd123: g = 40'h0008364100; 8'd124: g = 40'h0000770000; 8'd125: g = 40'h0041360800;
      8'd126: g = 40'h0201020402; 8'd127: g = 40'h3C2623263C; 8'd128: g = 40'h1EA1A16112;
      8'd129: g = 40'h3A4040207A; 8'd130: g = 40'h3854545559; 8'd131: g = 40'h2155557941;
      8'd132: g = 40'h2154547841; 8'd133: g = 40'h2155547840; 8'd134: g = 40'h2054557940;
      8'd135: g = 40'h0C1E527212; 8'd136: g = 40'h3955555559; 8'd137: g = 40'h3954545459;
      8'd138: g = 40'h3955545458; 8'd139: g = 40'h0000457C41; 8'd140: g = 40'h0002457D42;
      8'd141: g = 40'h0001457C40; 8'd142: g = 40'hF0292429F0; 8'd143: g = 40'hF0282528F0;
      8'd144: g = 40'h7C54554500; 8'd145: g = 40'h2054547C54; 8'd146: g = 40'h7C0A097F49;
      8'd147: g = 40'h3249494932; 8'd148: g = 40'h3248484832; 8'd149: g = 40'h324A484830;
      8'd150: g = 40'h3A4141217A; 8'd151: g = 40'h3A42402078; 8'd152: g = 40'h009DA0A07D;
      8'd153: g = 40'h3944444439; 8'd154: g = 40'h3D4040403D; 8'd155: g = 40'h3C24FF2424;
      8'd156: g = 40'h487E494366; 8'd157: g = 40'h2B2FFC2F2B; 8'd158: g = 40'hFF0929F620;
      8'd159: g = 40'hC0887E0903; 8'd160: g = 40'h2054547941; 8'd161: g = 40'h0000447D41;
      8'd162: g = 40'h3048484A32; 8'd163: g = 40'h384040227A; 8'd164: g = 40'h007A0A0A72;
      8'd165: g = 40'h7D0D19317D; 8'd166: g = 40'h2629292F28; 8'd167: g = 40'h2629292926;
      8'd168: g = 40'h30484D4020; 8'd169: g = 40'h3808080808; 8'd170: g = 40'h0808080838;
      8'd171: g = 40'h2F10C8ACBA; 8'd172: g = 40'h2F102834FA; 8'd173: g = 40'h00007B0000;
      8'd174: g = 40'h08142A1422; 8'd175: g = 40'h22142A1408; 8'd176: g = 40'hAA005500AA;
      8'd177: g = 40'hAA55AA55AA; 8'd178: g = 40'h000000FF00; 8'd179: g = 40'h101010FF00;
      8'd180: g = 40'h141414FF00; 8'd181: g = 40'h1010FF00FF; 8'd182: g = 40'h1010F010F0;
      8'd183: g = 40'h141414FC00; 8'd184: g = 40'h1414F700FF; 8'd185: g = 40'h0000FF00FF;
      8'd186: g = 40'h1414F404FC; 8'd187: g = 40'h141417101F; 8'd188: g = 40'h10101F101F;
      8'd189: g = 40'h1414141F00; 8'd190: g = 40'h101010F000; 8'd191: g = 40'h0000001F10;
      8'd192: g = 40'h1010101F10; 8'd193: g = 40'h101010F010; 8'd194: g = 40'h000000FF10;
      8'd195: g = 40'h1010101010; 8'd196: g = 40'h101010FF10; 8'd197: g = 40'h000000FF14;
      8'd198: g = 40'h0000FF00FF; 8'd199: g = 40'h00001F1017; 8'd200: g = 40'h0000FC04F4;
      8'd201: g = 40'h1414171017; 8'd202: g = 40'h1414F404F4; 8'd203: g = 40'h0000FF00F7;
      8'd204: g = 40'h1414141414; 8'd205: g = 40'h1414F700F7; 8'd206: g = 40'h1414141714;
      8'd207: g = 40'h10101F101F; 8'd208: g = 40'h141414F414; 8'd209: g = 40'h1010F010F0;
      8'd210: g = 40'h00001F101F; 8'd211: g = 40'h0000001F14; 8'd212: g = 40'h000000FC14;
      8'd213: g = 40'h0000F010F0; 8'd214: g = 40'h1010FF10FF; 8'd215: g = 40'h141414FF14;
      8'd216: g = 40'h1010101F00; 8'd217: g = 40'h000000F010; 8'd218: g = 40'hFFFFFFFFFF;
      8'd219: g = 40'hF0F0F0F0F0; 8'd220: g = 40'hFFFFFF0000; 8'd221: g = 40'h000000FFFF;
      8'd222: g = 40'h0F0F0F0F0F; 8'd223: g = 40'h3844443844; 8'd224: g = 40'h7C2A2A3E14;
      8'd225: g = 40'h7E02020606; 8'd226: g = 40'h027E027E02; 8'd227: g = 40'h6355494163;
      8'd228: g = 40'h3844443C04; 8'd229: g = 40'h407E201E20; 8'd230: g = 40'h06027E0202;
      8'd231: g = 40'h99A5E7A599; 8'd232: g = 40'h1C2A492A1C; 8'd233: g = 40'h4C7201724C;
      8'd234: g = 40'h304A4D4D30; 8'd235: g = 40'h3048784830; 8'd236: g = 40'hBC625A463D;
      8'd237: g = 40'h3E49494900; 8'd238: g = 40'h7E0101017E; 8'd239: g = 40'h2A2A2A2A2A;
      8'd240: g = 40'h44445F4444; 8'd241: g = 40'h40514A4440; 8'd242: g = 40'h40444A5140;
      8'd243: g = 40'h0000FF0103; 8'd244: g = 40'hE080FF0000; 8'd245: g = 40'h08086B6B08;
      8'd246: g = 40'h3612362436; 8'd247: g = 40'h060F090F06; 8'd248: g = 40'h0000181800;
      8'd249: g = 40'h0000101000; 8'd250: g = 40'h3040FF0101; 8'd251: g = 40'h001F01011E;
      8'd252: g = 40'h00191D1712; 8'd253: g = 40'h003C3C3C3C;
      default: g = 40'h0000000000;
    endcase
    return g;
  endfunction

endpackage

// ===== hw/rtl/sgtr_stream_if.sv =====
interface sgtr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/sgtr_front.sv =====
// front end: accepts a character request, looks up the glyph, queues a job
module sgtr_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  sgtr_stream_if.sink          char_if,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output logic [39:0]          job_bits_o,
  output logic                 job_restart_o,
  output logic [15:0]          job_start_o
);
  import sgtr_pkg::*;

  // two-entry queue
  logic [1:0]  vld_q, vld_d;
  logic [39:0] bits_q [2];
  logic [1:0]  rst_q;
  logic [15:0] st_q [2];
  logic        push, pop;
  logic        wr_head, wr_tail;

  assign char_if.ready = ~vld_q[1];
  assign push = char_if.valid & char_if.ready;
  assign pop  = vld_q[0] & job_ready_i;

  // slot that takes the incoming request
  assign wr_tail = push & (pop ? vld_q[1] : vld_q[0]);
  assign wr_head = push & ~wr_tail;

  assign job_valid_o   = vld_q[0];
  assign job_bits_o    = bits_q[0];
  assign job_restart_o = rst_q[0];
  assign job_start_o   = st_q[0];

  always_comb begin
    vld_d = vld_q;
    if (pop) vld_d = {1'b0, vld_q[1]};
    if (push) begin
      if (vld_d[0]) vld_d[1] = 1'b1;
      else vld_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload, shifted on pop
  always_ff @(posedge clk_i) begin
    if (wr_head) begin
      bits_q[0] <= glyph_bits(char_if.data.char_code);
      rst_q[0]  <= char_if.data.restart;
      st_q[0]   <= {char_if.data.start_x, char_if.data.start_y};
    end else if (pop) begin
      bits_q[0] <= bits_q[1];
      rst_q[0]  <= rst_q[1];
      st_q[0]   <= st_q[1];
    end
    if (wr_tail) begin
      bits_q[1] <= glyph_bits(char_if.data.char_code);
      rst_q[1]  <= char_if.data.restart;
      st_q[1]   <= {char_if.data.start_x, char_if.data.start_y};
    end
  end
endmodule

// ===== hw/rtl/sgtr_back.sv =====
// back end: walks the 40 cells of a glyph and emits fill requests
module sgtr_back (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        job_valid_i,
  output logic        job_ready_o,
  input  logic [39:0] job_bits_i,
  input  logic        job_restart_i,
  input  logic [15:0] job_start_i,
  input  logic [15:0] ink_i,
  input  logic [15:0] paper_i,
  input  logic [3:0]  scale_i,
  input  logic [7:0]  wrap_i,
  sgtr_stream_if.source fill_if
);
  import sgtr_pkg::*;

  logic        busy_q;
  logic [39:0] bits_q;
  logic [2:0]  col_q, row_q;
  logic [7:0]  cx_q, cy_q, px_q, py_q;
  logic        ov_q;
  fill_req_t   out_q;
  logic        adv, cell_last, take;
  logic [7:0]  nx, adv_x;

  assign adv       = busy_q & (~ov_q | fill_if.ready);
  assign cell_last = (col_q == 3'(GlyphCols - 1)) & (row_q == 3'(GlyphRows - 1));
  assign take      = ~busy_q & job_valid_i;
  assign job_ready_o = ~busy_q;
  assign fill_if.valid = ov_q;
  assign fill_if.data  = out_q;
  assign adv_x = 8'(AdvanceCells) * {4'b0000, scale_i};
  assign nx    = cx_q + adv_x;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ov_q   <= 1'b0;
      cx_q   <= '0;
      cy_q   <= '0;
      col_q  <= '0;
      row_q  <= '0;
    end else begin
      if (adv) ov_q <= 1'b1;
      else if (fill_if.ready) ov_q <= 1'b0;
      if (take) begin
        busy_q <= 1'b1;
        col_q  <= '0;
        row_q  <= '0;
        if (job_restart_i) begin
          cx_q <= job_start_i[15:8];
          cy_q <= job_start_i[7:0];
        end
      end else if (adv) begin
        if (cell_last) begin
          busy_q <= 1'b0;
          // cursor advance with line wrap
          if (nx > wrap_i) begin
            cx_q <= '0;
            cy_q <= cy_q + 8'({scale_i, 3'b000});
          end else begin
            cx_q <= nx;
          end
        end else if (row_q == 3'(GlyphRows - 1)) begin
          row_q <= '0;
          col_q <= col_q + 3'd1;
        end else begin
          row_q <= row_q + 3'd1;
        end
      end
    end
  end

  // cell offsets track col*scale and row*scale incrementally
  always_ff @(posedge clk_i) begin
    if (take) begin
      bits_q <= job_bits_i;
      px_q   <= job_restart_i ? job_start_i[15:8] : cx_q;
      py_q   <= job_restart_i ? job_start_i[7:0] : cy_q;
    end else if (adv) begin
      out_q.pix_x      <= px_q;
      out_q.pix_y      <= py_q;
      out_q.fill_color <= bits_q[6'(({3'd0, 3'(GlyphCols - 1)} - col_q) * 8) + 6'(row_q)]
                          ? ink_i : paper_i;
      out_q.side       <= scale_i;
      out_q.last       <= cell_last;
      if (row_q == 3'(GlyphRows - 1)) begin
        px_q <= px_q + 8'(scale_i);
        py_q <= cy_q;
      end else begin
        py_q <= py_q + 8'(scale_i);
      end
    end
  end
endmodule

// ===== hw/rtl/scaled_glyph_text_renderer_unit.sv =====
// scaled 5x8 glyph text renderer
// char_if takes one character request: a code plus an optional cursor restart.
// fill_if gives 40 block-fill requests per character, column by column with
// rows inner, each a square of side scale; the last one has last set.
// the cursor moves by 6*scale after the glyph and wraps to the next line
// when it passes wrap_limit; codes beyond the font draw paper color only.
// a request waits in the queue until the walker is free; the walker loads the
// glyph and registers each fill request. throughput: one fill request per cycle
// while the receiver is ready, from the single walker stepping one cell a cycle.
// a two-entry queue lets characters be taken while a glyph is drawn.
// a stalled receiver holds the output register and freezes the walker.
// reset clears the cursor to (0,0), ink white, paper black, scale 1,
// wrap limit 120; no clearing pass is needed.
// cfg_we_i writes register cfg_idx_i (ink, paper, scale, wrap); the user must
// write only while idle, and the block itself does not enforce it.
module scaled_glyph_text_renderer_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  sgtr_stream_if.sink   char_if,
  sgtr_stream_if.source fill_if
);
  import sgtr_pkg::*;

  logic [15:0] ink_q, paper_q;
  logic [3:0]  scale_q;
  logic [7:0]  wrap_q;
  logic        jv, jr, jrs;
  logic [39:0] jb;
  logic [15:0] js;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ink_q   <= 16'hFFFF;
      paper_q <= 16'h0000;
      scale_q <= 4'd1;
      wrap_q  <= 8'd120;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegInk:   ink_q   <= cfg_data_i;
        RegPaper: paper_q <= cfg_data_i;
        RegScale: scale_q <= cfg_data_i[3:0];
        RegWrap:  wrap_q  <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  sgtr_front u_front (
    .clk_i, .rst_ni, .char_if,
    .job_valid_o(jv), .job_ready_i(jr), .job_bits_o(jb),
    .job_restart_o(jrs), .job_start_o(js)
  );

  sgtr_back u_back (
    .clk_i, .rst_ni,
    .job_valid_i(jv), .job_ready_o(jr), .job_bits_i(jb),
    .job_restart_i(jrs), .job_start_i(js),
    .ink_i(ink_q), .paper_i(paper_q), .scale_i(scale_q), .wrap_i(wrap_q),
    .fill_if
  );
endmodule

// ===== hw/rtl/sgtr_checker.sv =====
module sgtr_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic fill_valid,
  input logic fill_ready,
  input logic fill_last,
  input logic [3:0] fill_side,
  input logic cfg_we_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_valid && !fill_ready |=> fill_valid) else $error("request dropped");
  a_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_valid && fill_ready && !fill_last && !$past(cfg_we_i) |=>
    !fill_valid || fill_side == $past(fill_side)) else $error("side changed in glyph");
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_valid && fill_ready && fill_last |=> !fill_valid || !fill_last)
    else $error("back to back last");
endmodule

bind scaled_glyph_text_renderer_unit sgtr_checker u_chk (
  .clk_i, .rst_ni,
  .fill_valid(fill_if.valid), .fill_ready(fill_if.ready),
  .fill_last(fill_if.data.last), .fill_side(fill_if.data.side),
  .cfg_we_i
);
